### hw/rtl/fully_connected_mac_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fully connected MAC engine
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FULLY_CONNECTED_MAC_ENGINE_MACROS_SVH
`define FULLY_CONNECTED_MAC_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCME_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCME_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/fcme_pkg.sv
// ----------------------------------------------------------------------------
// fcme_pkg
// Types and fixed widths shared by the MAC engine and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fcme_pkg;

	localparam int VAL_W     = 16;
	localparam int ROW_W     = 4;
	localparam int COL_W     = 6;
	localparam int FEAT_W    = 4;
	localparam int ACC_W     = 40;
	localparam int IN_CNT_W  = 7;
	localparam int OUT_CNT_W = 5;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CMD_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_WEIGHT = 2'd0,
		CMD_LOAD_BIAS   = 2'd1,
		CMD_DATA        = 2'd2
	} cmd_t;

	// One slot of the shared control pipeline.
	typedef struct packed {
		logic                    dat;
		logic                    done;
		logic                    bias_wr;
		logic [ROW_W-1:0]        row;
		logic signed [VAL_W-1:0] value;
	} pipe_t;

	// A weight write broadcast to the cells.
	typedef struct packed {
		logic                    en;
		logic [ROW_W-1:0]        row;
		logic signed [VAL_W-1:0] value;
	} wld_t;

	// One place of the result shift chain.
	typedef struct packed {
		logic                    valid;
		logic signed [VAL_W-1:0] result;
		logic [FEAT_W-1:0]       feature;
		logic                    last;
	} res_t;

endpackage

`default_nettype wire

### hw/rtl/fcme_cell.sv
// ----------------------------------------------------------------------------
// fcme_cell
// One output feature: weight column, accumulator, bias and one result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fcme_cell
	import fcme_pkg::*;
#(
	parameter int IN_MAX    = 64,
	parameter int FRAC_BITS = 8,
	parameter int IDX       = 0,
	parameter int POS_W     = 6,
	parameter int NOUT_W    = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wld_t              wld,
	input  wire logic [POS_W-1:0]  waddr,
	input  wire logic              rd_en,
	input  wire logic [POS_W-1:0]  raddr,
	input  wire pipe_t             s1,
	input  wire pipe_t             s2,
	input  wire pipe_t             s3,
	input  wire logic              adv,
	input  wire logic              load_res,
	input  wire logic              shift,
	input  wire logic [NOUT_W-1:0] nout,
	input  wire res_t              res_in,
	output res_t                   res_out
);

	localparam int PROD_W = 2 * VAL_W;
	localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'((2 ** (VAL_W - 1)) - 1);
	localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W+1)'(1);

	logic signed [VAL_W-1:0]  mem [IN_MAX];
	logic signed [VAL_W-1:0]  w_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  fin_s3;
	logic signed [VAL_W-1:0]  bias_q;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [ACC_W-1:0]  shifted;
	logic signed [ACC_W:0]    biased;
	logic signed [VAL_W-1:0]  sat;
	logic                     active;
	logic                     is_last;
	res_t                     res_q;

	assign active  = NOUT_W'(IDX) < nout;
	assign is_last = NOUT_W'(IDX + 1) == nout;

	assign acc_sum = acc_q + $signed({{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2});
	assign shifted = fin_s3 >>> FRAC_BITS;
	assign biased  = $signed({shifted[ACC_W-1], shifted})
		+ $signed({{(ACC_W + 1 - VAL_W){bias_q[VAL_W-1]}}, bias_q});

	always_comb begin
		if (biased > SAT_HI) begin
			sat = SAT_HI[VAL_W-1:0];
		end else if (biased < SAT_LO) begin
			sat = SAT_LO[VAL_W-1:0];
		end else begin
			sat = biased[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wld.en && (int'(wld.row) == IDX)) begin
			mem[waddr] <= wld.value;
		end
		if (rd_en) begin
			w_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= $signed(s1.value) * w_s1;
			if (s2.done) begin
				fin_s3 <= acc_sum;
			end
			if (s3.bias_wr && (int'(s3.row) == IDX)) begin
				bias_q <= s3.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			res_q <= '0;
		end else begin
			if (adv && s2.dat) begin
				if (s2.done) begin
					acc_q <= '0;
				end else if (active) begin
					acc_q <= acc_sum;
				end
			end
			if (load_res) begin
				res_q.valid   <= active;
				res_q.result  <= sat;
				res_q.feature <= FEAT_W'(IDX);
				res_q.last    <= is_last;
			end else if (shift) begin
				res_q <= res_in;
			end
		end
	end

	assign res_out = res_q;

endmodule

`default_nettype wire

### hw/rtl/fully_connected_mac_engine.sv
// ----------------------------------------------------------------------------
// fully_connected_mac_engine
// Fully connected layer y = W*x + b in Q8.8 on a row of per-feature cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction
// s_axis    in         weight load, bias load or one input element
// m_axis    out        one saturated output feature value
// cfg       in         register write, taken on every cycle with cfg_we high
//
// One input transaction is taken per cycle while s_axis_tready is high. The
// result of a vector passes pipeline slots s1, s2 and s3 after its final
// element, enters the result chain and leaves one output feature in use per
// cycle from the chain head while m_axis_tready is high.
// A vector completing while the chain still holds results waits in stage 3
// and holds s_axis_tready low until the chain is empty.
// Reset clears the accumulators, the element position, the pipeline and the
// result chain; weight and bias stores hold no value until written.
`default_nettype none

`include "fully_connected_mac_engine_macros.svh"

module fully_connected_mac_engine
	import fcme_pkg::*;
#(
	parameter int IN_MAX    = 64,
	parameter int OUT_MAX   = 16,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [31:0]          s_axis_tdata,  // out_index, in_index, value
	input  wire logic [CMD_W-1:0]     s_axis_tuser,  // command
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [23:0]               m_axis_tdata,  // result, out_feature
	output logic                      m_axis_tlast,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int POS_W  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
	localparam int CNT_W  = ($clog2(IN_MAX + 1) > IN_CNT_W) ? $clog2(IN_MAX + 1) : IN_CNT_W;
	localparam int NOUT_W = ($clog2(OUT_MAX + 1) > OUT_CNT_W) ?
		$clog2(OUT_MAX + 1) : OUT_CNT_W;
	localparam int COLX_W = ((POS_W > COL_W) ? POS_W : COL_W) + 1;

	logic [IN_CNT_W-1:0]     in_count_q;
	logic [OUT_CNT_W-1:0]    out_count_q;
	logic [POS_W-1:0]        pos_q;
	pipe_t                   s1, s2, s3, s1_next;
	wld_t                    wld;
	cmd_t                    cmd;
	logic [ROW_W-1:0]        row;
	logic [COL_W-1:0]        col;
	logic signed [VAL_W-1:0] value;
	logic                    accept;
	logic                    data_acc;
	logic                    bias_acc;
	logic                    vec_done;
	logic                    col_ok;
	logic [CNT_W-1:0]        in_cnt_x;
	logic [CNT_W-1:0]        eff_in;
	logic [CNT_W-1:0]        pos_next;
	logic [NOUT_W-1:0]       out_cnt_x;
	logic [NOUT_W-1:0]       nout;
	logic                    stall;
	logic                    adv;
	logic                    load_res;
	logic                    shift;
	logic                    busy;
	logic [OUT_MAX-1:0]      valid_vec;
	res_t                    chain [OUT_MAX+1];

	assign row   = s_axis_tdata[3:0];
	assign col   = s_axis_tdata[9:4];
	assign value = s_axis_tdata[25:10];

	assign in_cnt_x  = CNT_W'(in_count_q);
	assign out_cnt_x = NOUT_W'(out_count_q);

	always_comb begin
		if (in_cnt_x == '0) begin
			eff_in = CNT_W'(1);
		end else if (in_cnt_x > CNT_W'(IN_MAX)) begin
			eff_in = CNT_W'(IN_MAX);
		end else begin
			eff_in = in_cnt_x;
		end
		if (out_cnt_x == '0) begin
			nout = NOUT_W'(1);
		end else if (out_cnt_x > NOUT_W'(OUT_MAX)) begin
			nout = NOUT_W'(OUT_MAX);
		end else begin
			nout = out_cnt_x;
		end
	end

	assign pos_next = CNT_W'(pos_q) + CNT_W'(1);
	assign vec_done = pos_next >= eff_in;
	assign col_ok   = COLX_W'(col) < COLX_W'(IN_MAX);

	assign busy          = |valid_vec;
	assign stall         = s3.done && busy;
	assign adv           = !stall;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign load_res      = s3.done && adv;
	assign shift         = !chain[0].valid || m_axis_tready;

	always_comb begin
		cmd      = cmd_t'(s_axis_tuser);
		data_acc = 1'b0;
		bias_acc = 1'b0;
		wld.en   = 1'b0;
		wld.row  = row;
		wld.value = value;
		case (cmd)
			CMD_LOAD_WEIGHT: wld.en = accept && col_ok;
			CMD_LOAD_BIAS:   bias_acc = accept;
			CMD_DATA:        data_acc = accept;
			default: begin
			end
		endcase
		s1_next.dat     = data_acc;
		s1_next.done    = data_acc && vec_done;
		s1_next.bias_wr = bias_acc;
		s1_next.row     = row;
		s1_next.value   = value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= IN_CNT_W'(64);
			out_count_q <= OUT_CNT_W'(16);
			pos_q       <= '0;
			s1          <= '0;
			s2          <= '0;
			s3          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IN_COUNT:  in_count_q  <= cfg_data[IN_CNT_W-1:0];
					REG_OUT_COUNT: out_count_q <= cfg_data[OUT_CNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (data_acc) begin
				pos_q <= vec_done ? '0 : pos_next[POS_W-1:0];
			end
			if (adv) begin
				s1 <= s1_next;
				s2 <= s1;
				s3 <= s2;
			end
		end
	end

	assign chain[OUT_MAX] = '0;

	for (genvar k = 0; k < OUT_MAX; k++) begin : g_cell
		fcme_cell #(
			.IN_MAX   (IN_MAX),
			.FRAC_BITS(FRAC_BITS),
			.IDX      (k),
			.POS_W    (POS_W),
			.NOUT_W   (NOUT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wld     (wld),
			.waddr   (POS_W'(col)),
			.rd_en   (data_acc),
			.raddr   (pos_q),
			.s1      (s1),
			.s2      (s2),
			.s3      (s3),
			.adv     (adv),
			.load_res(load_res),
			.shift   (shift),
			.nout    (nout),
			.res_in  (chain[k+1]),
			.res_out (chain[k])
		);
		assign valid_vec[k] = chain[k].valid;
	end

	assign m_axis_tvalid = chain[0].valid;
	assign m_axis_tdata  = {4'd0, chain[0].feature, chain[0].result};
	assign m_axis_tlast  = chain[0].last;

	`FCME_CHECK_NOW(a_load_into_empty, load_res, !busy, "results loaded over a busy chain")
	`FCME_CHECK_NEXT(a_load_presents, load_res, m_axis_tvalid, "loaded vector not presented")
	`FCME_CHECK_NEXT(a_pos_restart, data_acc && vec_done, pos_q == '0, "position not cleared")

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: fully connected MAC engine testbench
// Streams weight loads, bias loads and input elements into the engine and
// checks every output feature against a Q8.8 layer predictor. Stimulus is a
// directed opening followed by random phases at changing vector sizes, with
// random idle gaps on both streams.
// ----------------------------------------------------------------------------

module tb_top;
	import fcme_pkg::*;

	localparam int FEATS = 16;
	localparam int COLS  = 64;
	localparam int FRAC  = 8;
	localparam int ITEMS = 410;
	localparam int TAIL  = 8;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} fc_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result;
		logic [FEAT_W-1:0]       feature;
		logic                    last;
	} feat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata = '0;
	logic [CMD_W-1:0]     s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	fully_connected_mac_engine i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Layer predictor state
	logic signed [VAL_W-1:0] w_mem [FEATS][COLS];
	logic signed [VAL_W-1:0] b_mem [FEATS];
	logic signed [ACC_W-1:0] acc_q24 [FEATS] = '{default: '0};
	int                      vec_pos = 0;
	logic [IN_CNT_W-1:0]     in_len = 7'd64;
	logic [OUT_CNT_W-1:0]    out_len = 5'd16;

	// Stimulus-side bookkeeping, used to keep every read on a written entry
	bit [COLS-1:0] g_w_set [FEATS] = '{default: '0};
	bit            g_b_set [FEATS] = '{default: 1'b0};
	int            g_pos = 0;
	int            g_in = COLS;
	int            g_out = FEATS;
	int            n_items = 0;

	fc_item_t pending_items[$];
	feat_t    expected_feats[$];
	fc_item_t bus_item;
	bit       calm = 1'b1;
	int       src_gap = 0;
	int       sink_gap = 0;
	int       err_cnt = 0;

	function automatic int eff_count(input int v, input int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return VAL_W'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return VAL_W'($urandom_range(0, 1023)) - 16'sd512;
		endcase
	endfunction

	function automatic void fc_layer_step(input fc_item_t it);
		int                        n_out;
		longint                    r;
		logic signed [2*VAL_W-1:0] prod;
		feat_t                     f;
		n_out = eff_count(out_len, FEATS);
		case (it.cmd)
			CMD_LOAD_WEIGHT: w_mem[it.row][it.col] = it.value;
			CMD_LOAD_BIAS: b_mem[it.row] = it.value;
			CMD_DATA: begin
				if (vec_pos < COLS) begin
					for (int k = 0; k < n_out; k++) begin
						prod = it.value * w_mem[k][vec_pos];
						acc_q24[k] = acc_q24[k] + prod;
					end
				end
				vec_pos++;
				if (vec_pos >= eff_count(in_len, COLS)) begin
					for (int k = 0; k < n_out; k++) begin
						r = longint'(acc_q24[k] >>> FRAC) + longint'(b_mem[k]);
						if (r > 32767)
							r = 32767;
						if (r < -32768)
							r = -32768;
						f.result = VAL_W'(r);
						f.feature = FEAT_W'(k);
						f.last = (k == n_out - 1);
						expected_feats.push_back(f);
					end
					acc_q24 = '{default: '0};
					vec_pos = 0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_item(input logic [CMD_W-1:0] cmd, input int row,
			input int col, input logic signed [VAL_W-1:0] v);
		fc_item_t it;
		it.cmd = cmd;
		it.row = ROW_W'(row);
		it.col = COL_W'(col);
		it.value = v;
		pending_items.push_back(it);
		n_items++;
	endfunction

	function automatic void queue_weight(input int row, input int col,
			input logic signed [VAL_W-1:0] v);
		queue_item(CMD_LOAD_WEIGHT, row, col, v);
		g_w_set[row][col] = 1'b1;
	endfunction

	function automatic void queue_bias(input int row, input logic signed [VAL_W-1:0] v);
		queue_item(CMD_LOAD_BIAS, row, $urandom_range(0, COLS - 1), v);
		g_b_set[row] = 1'b1;
	endfunction

	// Loads any weight or bias that the element or the vector end will read.
	function automatic void queue_element(input logic signed [VAL_W-1:0] v);
		for (int k = 0; k < g_out; k++) begin
			if (!g_w_set[k][g_pos])
				queue_weight(k, g_pos, rand_value());
			if (!g_b_set[k])
				queue_bias(k, rand_value());
		end
		queue_item(CMD_DATA, $urandom_range(0, FEATS - 1), $urandom_range(0, COLS - 1), v);
		g_pos++;
		if (g_pos >= g_in)
			g_pos = 0;
	endfunction

	function automatic void queue_noise();
		queue_item(CMD_UNUSED, $urandom_range(0, FEATS - 1), $urandom_range(0, COLS - 1),
			VAL_W'($urandom));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IN_COUNT) begin
			in_len = IN_CNT_W'(val);
			g_in = eff_count(in_len, COLS);
		end else begin
			out_len = OUT_CNT_W'(val);
			g_out = eff_count(out_len, FEATS);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || expected_feats.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic open_phase(input bit quiet);
		@(negedge clk);
		calm = quiet;
	endtask

	task automatic note_mismatch(input string what, input feat_t want, input feat_t got);
		if (err_cnt < 10)
			$display("%s: expected result %0d feature %0d last %0b, got result %0d feature %0d last %0b",
				what, want.result, want.feature, want.last, got.result, got.feature, got.last);
		err_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				fc_layer_step(bus_item);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					bus_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {6'b0, bus_item.value, bus_item.col, bus_item.row};
					s_axis_tuser <= bus_item.cmd;
					src_gap = calm ? 0 : pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		feat_t got;
		feat_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.result = m_axis_tdata[VAL_W-1:0];
				got.feature = m_axis_tdata[VAL_W+FEAT_W-1:VAL_W];
				got.last = m_axis_tlast;
				if (expected_feats.size() == 0) begin
					note_mismatch("Result with none pending", '0, got);
				end else begin
					want = expected_feats.pop_front();
					if (got !== want)
						note_mismatch("Result mismatch", want, got);
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				sink_gap = calm ? 0 : pick_gap();
			end
		end
	end

	initial begin
		int sel;
		int in_val;
		int out_val;
		int pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Single-element vectors over all sixteen features, saturating both ways.
		write_reg(REG_IN_COUNT, 0);
		write_reg(REG_OUT_COUNT, 31);
		open_phase(1'b1);
		queue_item(CMD_UNUSED, FEATS - 1, COLS - 1, -16'sd1);
		queue_weight(0, 0, 16'sh7fff);
		queue_weight(1, 0, 16'sh8000);
		queue_weight(2, 0, 16'sd256);
		queue_weight(3, 0, 16'sd1);
		queue_weight(FEATS - 1, COLS - 1, 16'sh8000);
		queue_bias(0, 16'sh7fff);
		queue_bias(1, 16'sh8000);
		queue_bias(2, 16'sd0);
		queue_bias(FEATS - 1, -16'sd1);
		queue_element(16'sh7fff);
		queue_element(16'sh8000);
		queue_element(-16'sd1);
		queue_element(16'sd0);
		queue_element(16'sd1);

		// Vector cut short by a lowered count, then widened mid-vector.
		wait_idle();
		write_reg(REG_IN_COUNT, 6);
		write_reg(REG_OUT_COUNT, 3);
		open_phase(1'b0);
		queue_element(rand_value());
		queue_element(rand_value());
		queue_weight(0, 3, 16'sd1000);
		queue_element(rand_value());
		queue_element(rand_value());
		wait_idle();
		write_reg(REG_IN_COUNT, 2);
		open_phase(1'b0);
		queue_element(rand_value());
		queue_element(rand_value());
		wait_idle();
		write_reg(REG_OUT_COUNT, 16);
		open_phase(1'b1);
		queue_element(rand_value());

		// Full-length vector on one feature.
		wait_idle();
		write_reg(REG_IN_COUNT, 100);
		write_reg(REG_OUT_COUNT, 0);
		open_phase(1'b0);
		repeat (COLS) queue_element(rand_value());

		while (n_items < ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 3) != 0) begin
				sel = $urandom_range(0, 9);
				in_val = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(COLS + 1, 127) :
					(sel == 2) ? COLS : $urandom_range(1, 8);
				write_reg(REG_IN_COUNT, in_val);
			end
			if (g_in > 8) begin
				write_reg(REG_OUT_COUNT, $urandom_range(0, 2));
			end else if ($urandom_range(0, 3) != 0) begin
				sel = $urandom_range(0, 9);
				out_val = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(FEATS + 1, 31) :
					(sel == 2) ? FEATS : $urandom_range(1, FEATS);
				write_reg(REG_OUT_COUNT, out_val);
			end
			open_phase($urandom_range(0, 3) == 0);
			repeat ($urandom_range(8, 40)) begin
				pick = $urandom_range(0, 99);
				if (pick < 6)
					queue_noise();
				else if (pick < 18)
					queue_weight($urandom_range(0, FEATS - 1), $urandom_range(0, COLS - 1),
						rand_value());
				else if (pick < 24)
					queue_bias($urandom_range(0, FEATS - 1), rand_value());
				else
					queue_element(rand_value());
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && expected_feats.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
